>>> hdl/rv32lsu_pkg.sv
`default_nettype none

package rv32lsu_pkg;

  localparam logic [6:0] OPC_LOAD  = 7'd3;
  localparam logic [6:0] OPC_STORE = 7'd35;

  localparam logic [2:0] F3_BYTE  = 3'd0;
  localparam logic [2:0] F3_HALF  = 3'd1;
  localparam logic [2:0] F3_WORD  = 3'd2;
  localparam logic [2:0] F3_BYTEU = 3'd4;
  localparam logic [2:0] F3_HALFU = 3'd5;

  // Index of the last byte of an access.
  localparam logic [1:0] LAST_BYTE = 2'd0;
  localparam logic [1:0] LAST_HALF = 2'd1;
  localparam logic [1:0] LAST_WORD = 2'd3;

  typedef struct packed {
    logic [31:0]        instruction;
    logic signed [31:0] base_value;
    logic signed [31:0] store_data;
  } lsu_in_t;

  typedef struct packed {
    logic               write_back;
    logic [4:0]         dest_reg;
    logic signed [31:0] load_value;
  } lsu_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic red_step;
    logic mem_en;
    logic capture;
    logic out_load;
    logic clr_en;
  } lsu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_last;
    logic nop;
    logic is_load;
    logic last_byte;
    logic out_free;
    logic clr_done;
  } lsu_sts_t;

endpackage

`default_nettype wire

>>> hdl/rv32lsu_ctrl.sv
`default_nettype none

module rv32lsu_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rv32lsu_pkg::lsu_sts_t sts_i,
  output rv32lsu_pkg::lsu_cmd_t      cmd_o
);
  import rv32lsu_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_REDUCE = 6'b000100,
    ST_MEM    = 6'b001000,
    ST_CAPT   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd_o.red_step = 1'b1;
        if (sts_i.red_last) begin
          state_d = sts_i.nop ? ST_FIN : ST_MEM;
        end
      end
      ST_MEM: begin
        cmd_o.mem_en = 1'b1;
        if (sts_i.is_load) begin
          state_d = ST_CAPT;
        end else if (sts_i.last_byte) begin
          state_d = ST_FIN;
        end
      end
      ST_CAPT: begin
        cmd_o.capture = 1'b1;
        state_d = sts_i.last_byte ? ST_FIN : ST_MEM;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/rv32lsu_dp.sv
`default_nettype none

module rv32lsu_dp #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire rv32lsu_pkg::lsu_in_t  in_data_i,
  input  wire rv32lsu_pkg::lsu_cmd_t cmd_i,
  output rv32lsu_pkg::lsu_sts_t      sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rv32lsu_pkg::lsu_out_t      out_data_o
);
  import rv32lsu_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW:0] MEM_END  = (AW + 1)'(MEM_BYTES);
  localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);
  localparam logic [31:0] MOD_VAL = 32'(MEM_BYTES);
  // Reciprocal of the memory size in 0.32 fixed point, rounded down.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(MEM_BYTES));

  // Steps of the address reduction, counted down.
  localparam logic [1:0] RED_QUOT = 2'd2;
  localparam logic [1:0] RED_REM  = 2'd1;

  logic [7:0] mem_q [MEM_BYTES];
  logic [7:0] rdata_q;

  // Item registers.
  logic [31:0]    rem_q;
  logic [31:0]    quot_q;
  logic [1:0]     red_cnt_q;
  logic [AW-1:0]  addr_q;
  logic [31:0]    data_q;
  logic [31:0]    acc_q;
  logic [4:0]     rd_q;
  logic [1:0]     last_idx_q;
  logic [1:0]     byte_idx_q;
  logic           is_load_q;
  logic           is_store_q;
  logic           sign_q;

  logic [AW-1:0]  clr_cnt_q;
  logic           out_valid_q;
  lsu_out_t       out_q;

  // Decode of the incoming instruction word.
  logic [6:0]  opcode;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, ea;
  logic        dec_load, dec_store;
  logic [1:0]  dec_last;

  always_comb begin
    opcode = in_data_i.instruction[6:0];
    f3     = in_data_i.instruction[14:12];
    imm_i  = {{20{in_data_i.instruction[31]}}, in_data_i.instruction[31:20]};
    imm_s  = {{20{in_data_i.instruction[31]}}, in_data_i.instruction[31:25],
              in_data_i.instruction[11:7]};
    dec_store = (opcode == OPC_STORE) &&
                (f3 == F3_BYTE || f3 == F3_HALF || f3 == F3_WORD);
    dec_load  = (opcode == OPC_LOAD) &&
                (f3 == F3_BYTE || f3 == F3_HALF || f3 == F3_WORD ||
                 f3 == F3_BYTEU || f3 == F3_HALFU);
    ea = unsigned'(in_data_i.base_value) + ((opcode == OPC_STORE) ? imm_s : imm_i);
    case (f3[1:0])
      2'd0:    dec_last = LAST_BYTE;
      2'd1:    dec_last = LAST_HALF;
      default: dec_last = LAST_WORD;
    endcase
  end

  // Address reduction modulo the memory size: a quotient estimate by reciprocal
  // multiplication, then the remainder, then one correcting subtraction. The
  // estimate is at most one short, so the remainder is below twice the size.
  logic [63:0] red_prod;
  logic [31:0] red_back;
  logic [31:0] red_fix;
  assign red_prod = 64'(rem_q) * 64'(RECIP);
  assign red_back = quot_q * MOD_VAL;
  assign red_fix  = (rem_q >= MOD_VAL) ? (rem_q - MOD_VAL) : rem_q;

  logic [AW:0] addr_inc;
  assign addr_inc = {1'b0, addr_q} + (AW + 1)'(1);

  always_comb begin
    sts_o           = '0;
    sts_o.red_last  = (red_cnt_q == '0);
    sts_o.nop       = !is_load_q && !is_store_q;
    sts_o.is_load   = is_load_q;
    sts_o.last_byte = (byte_idx_q == last_idx_q);
    sts_o.out_free  = !out_valid_q || out_ready_i;
    sts_o.clr_done  = (clr_cnt_q == MEM_LAST);
  end

  // Result formatting with sign or zero extension.
  lsu_out_t res;
  always_comb begin
    res = '0;
    if (is_load_q) begin
      res.write_back = 1'b1;
      res.dest_reg   = rd_q;
      if (sign_q && last_idx_q == LAST_BYTE) begin
        res.load_value = {{24{acc_q[7]}}, acc_q[7:0]};
      end else if (sign_q && last_idx_q == LAST_HALF) begin
        res.load_value = {{16{acc_q[15]}}, acc_q[15:0]};
      end else begin
        res.load_value = acc_q;
      end
    end
  end

  // Single-port byte memory with registered read data.
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  assign mem_addr  = cmd_i.clr_en ? clr_cnt_q : addr_q;
  assign mem_we    = cmd_i.clr_en || (cmd_i.mem_en && is_store_q);
  assign mem_wdata = cmd_i.clr_en ? 8'h00 : data_q[7:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rem_q      <= ea;
      rd_q       <= in_data_i.instruction[11:7];
      data_q     <= in_data_i.store_data;
      acc_q      <= '0;
      last_idx_q <= dec_last;
      sign_q     <= !f3[2];
    end
    if (cmd_i.red_step) begin
      case (red_cnt_q)
        RED_QUOT: quot_q <= red_prod[63:32];
        RED_REM:  rem_q  <= rem_q - red_back;
        default:  addr_q <= red_fix[AW-1:0];
      endcase
    end
    if (cmd_i.mem_en) begin
      addr_q <= (addr_inc == MEM_END) ? '0 : addr_inc[AW-1:0];
      if (is_store_q) begin
        data_q <= data_q >> 8;
      end
    end
    if (cmd_i.capture) begin
      case (byte_idx_q)
        2'd0:    acc_q[7:0]   <= rdata_q;
        2'd1:    acc_q[15:8]  <= rdata_q;
        2'd2:    acc_q[23:16] <= rdata_q;
        default: acc_q[31:24] <= rdata_q;
      endcase
    end
    if (cmd_i.out_load) begin
      out_q <= res;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q   <= '0;
      byte_idx_q  <= '0;
      is_load_q   <= 1'b0;
      is_store_q  <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        red_cnt_q  <= RED_QUOT;
        byte_idx_q <= '0;
        is_load_q  <= dec_load;
        is_store_q <= dec_store;
      end else if (cmd_i.red_step && red_cnt_q != '0) begin
        red_cnt_q <= red_cnt_q - 2'd1;
      end
      if ((cmd_i.mem_en && is_store_q) || cmd_i.capture) begin
        byte_idx_q <= byte_idx_q + 2'd1;
      end
      if (cmd_i.clr_en && clr_cnt_q != MEM_LAST) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register loaded while an unread item is held");

  a_capture_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.capture |-> ($past(cmd_i.mem_en) && is_load_q))
    else $error("read data captured without a preceding load access");

  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_en |-> ({1'b0, addr_q} < MEM_END))
    else $error("byte address outside the memory");

  a_byte_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mem_en |-> (byte_idx_q <= last_idx_q))
    else $error("access runs past the last byte of the item");

endmodule

`default_nettype wire

>>> hdl/rv32_load_store_unit_top.sv
// Sequence: address reduction by quotient, remainder and correction, then one access per
// byte for a store or an access and a capture per byte for a load, then result formatting.
// Throughput: one item at a time; the next item is taken in the idle cycle after the result
// has moved to the output register, so a held result does not block a new item.
// Reset: rst_ni clears the control state at once, then a clearing pass zeroes the memory
// byte by byte, during which no item is taken.
`default_nettype none

module rv32_load_store_unit_top #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire rv32lsu_pkg::lsu_in_t in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output rv32lsu_pkg::lsu_out_t     out_data_o
);
  import rv32lsu_pkg::*;

  // The controller sequences each item: reduction of the effective address modulo the
  // memory size by reciprocal multiplication and one correcting subtraction, one memory
  // access per byte (none for a non-memory item), and the final load into the output register.
  lsu_cmd_t cmd;
  lsu_sts_t sts;

  rv32lsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the decoded item, the byte-wide data memory and the output
  // register that parts the result side from the input side.
  rv32lsu_dp #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
